// ----- sv/s4wl_pkg.sv -----
// shared types and constants for the socks4 request whitelist check
`default_nettype none

package s4wl_pkg;

  localparam int unsigned NumRules  = 8;
  localparam int unsigned RuleSlots = 8;
  localparam int unsigned RuleW     = 38;
  localparam int unsigned RuleIdxW  = $clog2(RuleSlots);
  localparam int unsigned PaddrW    = RuleIdxW + 3;
  localparam int unsigned PdataW    = 64;
  localparam int unsigned PosW      = 4;
  localparam int unsigned ReplyW    = 7;

  // byte positions in the request header
  localparam logic [PosW-1:0] PosVersion = 4'd0;
  localparam logic [PosW-1:0] PosCommand = 4'd1;
  localparam logic [PosW-1:0] PosPortHi  = 4'd2;
  localparam logic [PosW-1:0] PosPortLo  = 4'd3;
  localparam logic [PosW-1:0] PosUserId  = 4'd8;

  localparam logic [7:0] CmdConnect = 8'd1;

  localparam logic [ReplyW-1:0] ReplyGranted = 7'd90;
  localparam logic [ReplyW-1:0] ReplyDenied  = 7'd91;

  typedef logic [RuleW-1:0] rule_t;

  typedef struct packed {
    logic [7:0]  version;
    logic [7:0]  command;
    logic [15:0] dest_port;
    logic [31:0] dest_address;
    logic [31:0] user_id;
  } s4wl_req_t;

endpackage

`default_nettype wire

// ----- sv/s4wl_cfg.sv -----
// apb register file holding the whitelist rules
`default_nettype none

module s4wl_cfg (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire  [s4wl_pkg::PaddrW-1:0]          paddr,
  input  wire  [s4wl_pkg::PdataW-1:0]          pwdata,
  output logic [s4wl_pkg::PdataW-1:0]          prdata,
  output logic                                 pready,
  output s4wl_pkg::rule_t [s4wl_pkg::RuleSlots-1:0] rules_o
);
  import s4wl_pkg::*;

  rule_t [RuleSlots-1:0] rules_q;
  logic [RuleIdxW-1:0]   idx;
  logic                  wr_en;

  assign idx   = paddr[PaddrW-1:3];
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rules_q <= '0;
    end else if (wr_en) begin
      rules_q[idx] <= pwdata[RuleW-1:0];
    end
  end

  assign prdata  = {{(PdataW-RuleW){1'b0}}, rules_q[idx]};
  assign rules_o = rules_q;

endmodule

`default_nettype wire

// ----- sv/s4wl_parse.sv -----
// byte-serial request parser holding the header fields and user id
`default_nettype none

module s4wl_parse (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 accept_i,
  input  wire  [7:0]          byte_i,
  output s4wl_pkg::s4wl_req_t req_o,
  output logic                done_o
);
  import s4wl_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      version_q, version_d;
  logic [7:0]      command_q, command_d;
  logic [15:0]     port_q, port_d;
  logic [31:0]     addr_q, addr_d;
  logic [31:0]     uid_q, uid_d;
  logic            in_header;

  assign in_header = ~pos_q[PosW-1];
  // a zero byte ends the request only in the user-id phase
  assign done_o    = accept_i & ~in_header & (byte_i == 8'd0);

  always_comb begin
    pos_d     = pos_q;
    version_d = version_q;
    command_d = command_q;
    port_d    = port_q;
    addr_d    = addr_q;
    uid_d     = uid_q;
    if (accept_i) begin
      if (in_header) begin
        case (pos_q)
          PosVersion: version_d = byte_i;
          PosCommand: command_d = byte_i;
          PosPortHi:  port_d    = {byte_i, port_q[7:0]};
          PosPortLo:  port_d    = {port_q[15:8], byte_i};
          default:    addr_d    = {addr_q[23:0], byte_i};
        endcase
        pos_d = pos_q + 4'd1;
      end else if (byte_i != 8'd0) begin
        uid_d = {uid_q[23:0], byte_i};
        pos_d = PosUserId;
      end else begin
        uid_d = '0;
        pos_d = PosVersion;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosVersion;
      uid_q <= '0;
    end else begin
      pos_q <= pos_d;
      uid_q <= uid_d;
    end
  end

  // header fields are fully rewritten before every result
  always_ff @(posedge clk_i) begin
    version_q <= version_d;
    command_q <= command_d;
    port_q    <= port_d;
    addr_q    <= addr_d;
  end

  assign req_o.version      = version_q;
  assign req_o.command      = command_q;
  assign req_o.dest_port    = port_q;
  assign req_o.dest_address = addr_q;
  assign req_o.user_id      = uid_q;

endmodule

`default_nettype wire

// ----- sv/s4wl_match.sv -----
// parallel compare of command and address against the whitelist rules
`default_nettype none

module s4wl_match (
  input  s4wl_pkg::rule_t [s4wl_pkg::RuleSlots-1:0] rules_i,
  input  wire  [7:0]                               command_i,
  input  wire  [31:0]                              address_i,
  output logic                                     granted_o
);
  import s4wl_pkg::*;

  logic [NumRules-1:0] hit;

  always_comb begin
    for (int i = 0; i < NumRules; i++) begin
      hit[i] = (rules_i[i][1:0] != 2'd0) &&
               (command_i == {6'd0, rules_i[i][1:0]});
      for (int j = 0; j < 4; j++) begin
        // octet j sits at address bits 31-8j and rule bits 37-8j
        if (!rules_i[i][2+j] &&
            (address_i[24-8*j +: 8] != rules_i[i][30-8*j +: 8])) begin
          hit[i] = 1'b0;
        end
      end
    end
  end

  assign granted_o = |hit;

endmodule

`default_nettype wire

// ----- sv/socks4_request_whitelist_check.sv -----
// top level of the socks4 request parser with whitelist check
// usage:
//   request bytes enter on the in_* channel, one item per byte, in order:
//   version, command, port high, port low, four address octets, then
//   user-id bytes closed by a zero byte. zero bytes inside the header
//   are data. only the closing zero produces a result item on out_*.
//   the apb port holds eight 38-bit rules at byte addresses 8*i; write
//   them only while no request is in flight.
// result: the result item is valid in the cycle after the closing zero is
//   accepted; the rule compare runs in the accepting cycle off the held
//   header registers and lands in the result register.
// throughput: one byte per cycle while in_ready_o is high. in_ready_o stays high while the result
//   register is empty or is being drained in the same cycle.
// stall: if the receiver holds out_ready_i low, the result stays in the
//   output register and input is held off until it is taken.
// reset: all rules clear (every rule disabled, so connect is denied),
//   the parser expects a version byte and no result is pending.
`default_nettype none

module socks4_request_whitelist_check (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // apb configuration port
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [s4wl_pkg::PaddrW-1:0] paddr,
  input  wire  [s4wl_pkg::PdataW-1:0] pwdata,
  output logic [s4wl_pkg::PdataW-1:0] prdata,
  output logic                        pready,
  // request byte stream
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [7:0]                  request_byte_i,
  // result channel
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [7:0]                  version_o,
  output logic [7:0]                  command_o,
  output logic [15:0]                 dest_port_o,
  output logic [31:0]                 dest_address_o,
  output logic [31:0]                 user_id_o,
  output logic                        granted_o,
  output logic [s4wl_pkg::ReplyW-1:0] reply_code_o
);
  import s4wl_pkg::*;

  rule_t [RuleSlots-1:0] rules;
  s4wl_req_t             req;
  logic                  accept;
  logic                  done;
  logic                  granted;

  logic                  out_valid_q;
  s4wl_req_t             res_q;
  logic                  granted_q;
  logic [ReplyW-1:0]     reply_q, reply_d;

  s4wl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rules_o (rules)
  );

  // input side only waits when a finished result is still unclaimed
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  s4wl_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (request_byte_i),
    .req_o    (req),
    .done_o   (done)
  );

  // the held command and address are final once the closing zero arrives
  s4wl_match u_match (
    .rules_i   (rules),
    .command_i (req.command),
    .address_i (req.dest_address),
    .granted_o (granted)
  );

  // connect that hit no rule is denied; bind and unknown commands get 90
  assign reply_d = ((req.command == CmdConnect) && !granted) ? ReplyDenied : ReplyGranted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q     <= req;
      granted_q <= granted;
      reply_q   <= reply_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign version_o      = res_q.version;
  assign command_o      = res_q.command;
  assign dest_port_o    = res_q.dest_port;
  assign dest_address_o = res_q.dest_address;
  assign user_id_o      = res_q.user_id;
  assign granted_o      = granted_q;
  assign reply_code_o   = reply_q;

endmodule

`default_nettype wire
